/* src/hvn_pkg.sv */
// Shared widths, codes and side-band types for the heightmap vertex normal block.
package hvn_pkg;

   localparam int BYTE_W      = 8;
   localparam int GAIN_W      = 18;
   localparam int HEIGHT_W    = 19;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 19;
   localparam int LANES       = 4;
   localparam int DIFF_W      = 27;
   localparam int MAG_W       = 26;
   localparam int SQ_W        = 52;
   localparam int LEN_W       = 54;
   localparam int ROOT_W      = LEN_W / 2;
   localparam int INNER_BITS  = 24;
   localparam int INNER_Q_W   = INNER_BITS + 1;
   localparam int ACC_W       = 28;
   localparam int ACC_MAG_W   = 27;
   localparam int ACC_SQ_W    = 54;
   localparam int SUM_W       = 56;
   localparam int SUM_ROOT_W  = SUM_W / 2;
   localparam int NORM_W      = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_GAIN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_OFFSET = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
   localparam logic [MAG_W-1:0]  UNIT_Y     = MAG_W'(65536);
   localparam logic [LEN_W-1:0]  LEN_BIAS   = LEN_W'(1) << 32;

   // quadrants: down/left, right/down, up/right, left/up
   localparam int LANE_LD = 0;
   localparam int LANE_RD = 1;
   localparam int LANE_UR = 2;
   localparam int LANE_LU = 3;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic [LANES-1:0]           mask;
   } common_type;

   typedef struct packed {
      logic             neg_p;
      logic             neg_q;
      logic [MAG_W-1:0] mag_p;
      logic [MAG_W-1:0] mag_q;
   } lane_type;

   typedef struct packed {
      common_type common;
      lane_type   lane;
   } lane_side_type;

   typedef struct packed {
      common_type common;
      logic       neg_p;
      logic       neg_q;
   } ldiv_side_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0]  height;
      logic                        no_quad;
      logic [2:0]                  neg;
      logic [2:0][ACC_MAG_W-1:0]   mag;
   } final_side_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic                       no_quad;
      logic [2:0]                 neg;
   } fdiv_side_type;

endpackage

/* src/heightmap_vertex_normal.sv */
// Heightmap vertex normal: top level with quadrant lanes, normal sum and final normalize.
//
// Each request carries one heightmap vertex: the center byte, four neighbor bytes
// and four flags that say which neighbors exist. Each result carries the scaled
// vertex height (Q19.0, saturated), the unit normal in Q1.NORMAL_FRAC_BITS and a
// flag set when no quadrant had both neighbors, in which case the normal is zero.
// Both channels use valid/stall; a request is taken when req_valid is high and
// req_stall low. Gain and offset are written on the csr port, which is always
// ready; write them only while no request is in flight.
// One request can enter every cycle unless rsp_stall holds a waiting result; the depth
// is set mainly by the two square root pipelines (one bit per stage) and the two divider
// pipelines (one quotient bit per stage).
// The whole pipeline advances together. When rsp_stall holds a waiting result,
// every stage holds and req_stall is raised; empty stages still fill while the
// output register is empty. Reset empties the pipeline and loads gain 1.0 and
// offset 0.
module heightmap_vertex_normal #(
   parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [hvn_pkg::BYTE_W-1:0]           req_center_height,
   input  logic [hvn_pkg::BYTE_W-1:0]           req_left_height,
   input  logic [hvn_pkg::BYTE_W-1:0]           req_right_height,
   input  logic [hvn_pkg::BYTE_W-1:0]           req_up_height,
   input  logic [hvn_pkg::BYTE_W-1:0]           req_down_height,
   input  logic                                 req_has_left,
   input  logic                                 req_has_right,
   input  logic                                 req_has_up,
   input  logic                                 req_has_down,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hvn_pkg::HEIGHT_W-1:0]  rsp_vertex_height,
   output logic signed [hvn_pkg::NORM_W-1:0]    rsp_normal_x,
   output logic signed [hvn_pkg::NORM_W-1:0]    rsp_normal_y,
   output logic signed [hvn_pkg::NORM_W-1:0]    rsp_normal_z,
   output logic                                 rsp_no_quadrant,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hvn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hvn_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int L   = hvn_pkg::LANES;
   localparam int QW  = NORMAL_FRAC_BITS + 1;
   localparam int NORM_CAP = (NORMAL_FRAC_BITS >= 15) ? 32767 : (1 << NORMAL_FRAC_BITS);
   localparam int AW  = hvn_pkg::ACC_W;

   logic                                   en;
   logic [hvn_pkg::GAIN_W-1:0]             gain_ff;
   logic signed [hvn_pkg::HEIGHT_W-1:0]    offset_ff;

   logic                                   fr_valid;
   logic [L-1:0][hvn_pkg::LEN_W-1:0]       fr_len;
   hvn_pkg::lane_side_type [L-1:0]         fr_side;

   logic [L-1:0]                           lsq_valid;
   logic [L-1:0][hvn_pkg::ROOT_W-1:0]      lsq_root;
   hvn_pkg::lane_side_type [L-1:0]         lsq_side;
   hvn_pkg::ldiv_side_type [L-1:0]         ldv_in_side;
   logic [L-1:0][2:0][hvn_pkg::MAG_W-1:0]  ldv_mag;

   logic [L-1:0]                              ldv_valid;
   logic [L-1:0][2:0][hvn_pkg::INNER_Q_W-1:0] ldv_quo;
   hvn_pkg::ldiv_side_type [L-1:0]            ldv_side;

   logic                          t1_ff, t2_ff, t3_ff;
   logic signed [AW-1:0]          acc_ff [3];
   logic signed [AW-1:0]          acc_in [3];
   logic signed [AW-1:0]          term;
   hvn_pkg::final_side_type       s1_ff, s2_ff, s3_ff;
   logic [hvn_pkg::ACC_SQ_W-1:0]  sq_ff [3];
   logic [hvn_pkg::SUM_W-1:0]     t_ff;

   logic                              fsq_valid;
   logic [hvn_pkg::SUM_ROOT_W-1:0]    fsq_root;
   hvn_pkg::final_side_type           fsq_side;
   hvn_pkg::fdiv_side_type            fdv_in_side;

   logic                              fdv_valid;
   logic [2:0][QW-1:0]                fdv_quo;
   hvn_pkg::fdiv_side_type            fdv_side;

   logic                              rsp_valid_ff;
   logic signed [hvn_pkg::HEIGHT_W-1:0] height_ff;
   logic signed [hvn_pkg::NORM_W-1:0] nrm_ff [3];
   logic signed [hvn_pkg::NORM_W-1:0] nrm_in [3];
   logic                              noq_ff;
   logic [QW-1:0]                     qc;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= hvn_pkg::GAIN_RESET;
         offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hvn_pkg::CSR_HEIGHT_GAIN:   gain_ff   <= csr_data[hvn_pkg::GAIN_W-1:0];
            hvn_pkg::CSR_HEIGHT_OFFSET: offset_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   hvn_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .center_height (req_center_height),
      .left_height   (req_left_height),
      .right_height  (req_right_height),
      .up_height     (req_up_height),
      .down_height   (req_down_height),
      .has_left      (req_has_left),
      .has_right     (req_has_right),
      .has_up        (req_has_up),
      .has_down      (req_has_down),
      .height_gain   (gain_ff),
      .height_offset (offset_ff),
      .out_valid     (fr_valid),
      .out_len       (fr_len),
      .out_side      (fr_side)
   );

   for (genvar i = 0; i < L; i++) begin : g_lane
      hvn_isqrt #(
         .W  (hvn_pkg::LEN_W),
         .SW ($bits(hvn_pkg::lane_side_type))
      ) u_isqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (fr_valid),
         .in_val    (fr_len[i]),
         .in_side   (fr_side[i]),
         .out_valid (lsq_valid[i]),
         .out_root  (lsq_root[i]),
         .out_side  (lsq_side[i])
      );

      always_comb begin
         ldv_mag[i]               = {lsq_side[i].lane.mag_q, hvn_pkg::UNIT_Y,
                                     lsq_side[i].lane.mag_p};
         ldv_in_side[i].common    = lsq_side[i].common;
         ldv_in_side[i].neg_p     = lsq_side[i].lane.neg_p;
         ldv_in_side[i].neg_q     = lsq_side[i].lane.neg_q;
      end

      hvn_div #(
         .NC (3),
         .MW (hvn_pkg::MAG_W),
         .DW (hvn_pkg::ROOT_W),
         .SH (hvn_pkg::INNER_BITS),
         .SW ($bits(hvn_pkg::ldiv_side_type))
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (lsq_valid[i]),
         .in_mag    (ldv_mag[i]),
         .in_den    (lsq_root[i]),
         .in_side   (ldv_in_side[i]),
         .out_valid (ldv_valid[i]),
         .out_quo   (ldv_quo[i]),
         .out_side  (ldv_side[i])
      );
   end

   // sum of the contributing quadrant normals
   always_comb begin
      term = '0;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = '0;
         for (int i = 0; i < L; i++) begin
            term = $signed(AW'(ldv_quo[i][k]));
            if ((k == 0 && ldv_side[i].neg_p) || (k == 2 && ldv_side[i].neg_q)) begin
               term = -term;
            end
            if (ldv_side[0].common.mask[i]) begin
               acc_in[k] = acc_in[k] + term;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= 1'b0;
         t2_ff <= 1'b0;
         t3_ff <= 1'b0;
      end else if (en) begin
         t1_ff <= ldv_valid[0];
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= acc_in[k];
         end
         s1_ff.height  <= ldv_side[0].common.height;
         s1_ff.no_quad <= (ldv_side[0].common.mask == '0);
         s1_ff.neg     <= '0;
         s1_ff.mag     <= '0;

         s2_ff.height  <= s1_ff.height;
         s2_ff.no_quad <= s1_ff.no_quad;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]        <= hvn_pkg::ACC_SQ_W'(acc_ff[k] * acc_ff[k]);
            s2_ff.neg[k]    <= acc_ff[k][AW-1];
            s2_ff.mag[k]    <= hvn_pkg::ACC_MAG_W'(acc_ff[k][AW-1] ? -acc_ff[k] : acc_ff[k]);
         end

         s3_ff <= s2_ff;
         t_ff  <= hvn_pkg::SUM_W'(sq_ff[0]) + hvn_pkg::SUM_W'(sq_ff[1])
                  + hvn_pkg::SUM_W'(sq_ff[2]);
      end
   end

   hvn_isqrt #(
      .W  (hvn_pkg::SUM_W),
      .SW ($bits(hvn_pkg::final_side_type))
   ) u_fisqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t3_ff),
      .in_val    (t_ff),
      .in_side   (s3_ff),
      .out_valid (fsq_valid),
      .out_root  (fsq_root),
      .out_side  (fsq_side)
   );

   always_comb begin
      fdv_in_side.height  = fsq_side.height;
      fdv_in_side.no_quad = fsq_side.no_quad;
      fdv_in_side.neg     = fsq_side.neg;
   end

   hvn_div #(
      .NC (3),
      .MW (hvn_pkg::ACC_MAG_W),
      .DW (hvn_pkg::SUM_ROOT_W),
      .SH (NORMAL_FRAC_BITS),
      .SW ($bits(hvn_pkg::fdiv_side_type))
   ) u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fsq_valid),
      .in_mag    (fsq_side.mag),
      .in_den    (fsq_root),
      .in_side   (fdv_in_side),
      .out_valid (fdv_valid),
      .out_quo   (fdv_quo),
      .out_side  (fdv_side)
   );

   always_comb begin
      qc = '0;
      for (int k = 0; k < 3; k++) begin
         qc = (fdv_quo[k] > QW'(NORM_CAP)) ? QW'(NORM_CAP) : fdv_quo[k];
         nrm_in[k] = $signed(hvn_pkg::NORM_W'(qc));
         if (fdv_side.neg[k]) begin
            nrm_in[k] = -nrm_in[k];
         end
         if (fdv_side.no_quad) begin
            nrm_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fdv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         height_ff <= fdv_side.height;
         noq_ff    <= fdv_side.no_quad;
         for (int k = 0; k < 3; k++) begin
            nrm_ff[k] <= nrm_in[k];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_height = height_ff;
   assign rsp_normal_x      = nrm_ff[0];
   assign rsp_normal_y      = nrm_ff[1];
   assign rsp_normal_z      = nrm_ff[2];
   assign rsp_no_quadrant   = noq_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lsq_valid == {L{lsq_valid[0]}} && ldv_valid == {L{ldv_valid[0]}})
      else $error("quadrant lanes out of step");

   a_noq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_quadrant |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("normal not zero without quadrant");

   a_normal_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_normal_y[hvn_pkg::NORM_W-1])
      else $error("normal points down");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

/* src/hvn_isqrt.sv */
// Pipelined floor square root, one root bit per register stage, with side-band.
module hvn_isqrt #(
   parameter int W  = 54,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [W-1:0]    in_val,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [W/2-1:0]  out_root,
   output logic [SW-1:0]   out_side
);

   localparam int N  = W / 2;
   localparam int RW = N + 2;

   logic          vld_ff  [N];
   logic [W-1:0]  val_ff  [N];
   logic [RW-1:0] rem_ff  [N];
   logic [N-1:0]  root_ff [N];
   logic [SW-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic          p_vld;
      logic [W-1:0]  p_val;
      logic [RW-1:0] p_rem;
      logic [N-1:0]  p_root;
      logic [SW-1:0] p_side;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [N-1:0]  root_in;
      logic          ge;

      if (k == 0) begin : g_first
         assign p_vld  = in_valid;
         assign p_val  = in_val;
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_side = in_side;
      end else begin : g_next
         assign p_vld  = vld_ff[k-1];
         assign p_val  = val_ff[k-1];
         assign p_rem  = rem_ff[k-1];
         assign p_root = root_ff[k-1];
         assign p_side = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {p_rem[RW-3:0], p_val[W-1 -: 2]};
         trial   = {p_root, 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {p_root[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[k]  <= p_val << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

/* src/hvn_div.sv */
// Pipelined rounded divider: round(mag * 2^SH / den), one quotient bit per stage.
module hvn_div #(
   parameter int NC = 3,
   parameter int MW = 26,
   parameter int DW = 27,
   parameter int SH = 24,
   parameter int SW = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [NC-1:0][MW-1:0]    in_mag,
   input  logic [DW-1:0]            in_den,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   output logic [NC-1:0][SH:0]      out_quo,
   output logic [SW-1:0]            out_side
);

   // quotient is known to stay below 2^QW
   localparam int QW = SH + 1;
   localparam int RW = DW + 2;
   localparam int LW = RW + QW;

   logic                   vld_ff  [QW+1];
   logic [NC-1:0][LW-1:0]  w_ff    [QW+1];
   logic [RW-1:0]          dd_ff   [QW+1];
   logic [SW-1:0]          side_ff [QW+1];

   for (genvar k = 0; k <= QW; k++) begin : g_stage
      logic                  p_vld;
      logic [SW-1:0]         p_side;
      logic [NC-1:0][LW-1:0] w_in;
      logic [RW-1:0]         dd_in;

      if (k == 0) begin : g_setup
         assign p_vld  = in_valid;
         assign p_side = in_side;
         always_comb begin
            dd_in = RW'(in_den) << 1;
            for (int c = 0; c < NC; c++) begin
               w_in[c] = (LW'(in_mag[c]) << QW) + LW'(in_den);
            end
         end
      end else begin : g_step
         logic [RW-1:0] t;
         logic          ge;
         assign p_vld  = vld_ff[k-1];
         assign p_side = side_ff[k-1];
         always_comb begin
            dd_in = dd_ff[k-1];
            t     = '0;
            ge    = 1'b0;
            for (int c = 0; c < NC; c++) begin
               t  = w_ff[k-1][c][LW-2:QW-1];
               ge = (t >= dd_ff[k-1]);
               if (ge) begin
                  t = t - dd_ff[k-1];
               end
               w_in[c] = {t, w_ff[k-1][c][QW-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[k]    <= w_in;
            dd_ff[k]   <= dd_in;
            side_ff[k] <= p_side;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         out_quo[c] = w_ff[QW][c][QW-1:0];
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

/* src/hvn_front.sv */
// Front stages: neighbor differences, quadrant vectors, squared lengths and vertex height.
module hvn_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [hvn_pkg::BYTE_W-1:0]             center_height,
   input  logic [hvn_pkg::BYTE_W-1:0]             left_height,
   input  logic [hvn_pkg::BYTE_W-1:0]             right_height,
   input  logic [hvn_pkg::BYTE_W-1:0]             up_height,
   input  logic [hvn_pkg::BYTE_W-1:0]             down_height,
   input  logic                                   has_left,
   input  logic                                   has_right,
   input  logic                                   has_up,
   input  logic                                   has_down,
   input  logic [hvn_pkg::GAIN_W-1:0]             height_gain,
   input  logic signed [hvn_pkg::HEIGHT_W-1:0]    height_offset,
   output logic                                   out_valid,
   output logic [hvn_pkg::LANES-1:0][hvn_pkg::LEN_W-1:0] out_len,
   output hvn_pkg::lane_side_type [hvn_pkg::LANES-1:0]   out_side
);

   localparam int L = hvn_pkg::LANES;
   localparam int DW = hvn_pkg::DIFF_W;
   localparam int HW = hvn_pkg::HEIGHT_W;

   // stage 1: products
   logic                 v1_ff;
   logic [25:0]          cg_ff;
   logic signed [DW-1:0] dl_ff, dr_ff, du_ff, dd_ff;
   logic [L-1:0]         mask_ff;
   // stage 2: quadrant vectors and height
   logic                 v2_ff;
   logic signed [DW-1:0] p_ff [L];
   logic signed [DW-1:0] q_ff [L];
   hvn_pkg::common_type  c2_ff;
   // stage 3: squares
   logic                 v3_ff;
   logic [hvn_pkg::SQ_W-1:0] sqp_ff [L];
   logic [hvn_pkg::SQ_W-1:0] sqq_ff [L];
   hvn_pkg::lane_type    ln3_ff [L];
   hvn_pkg::common_type  c3_ff;
   // stage 4: lengths
   logic                 v4_ff;
   logic [L-1:0][hvn_pkg::LEN_W-1:0] len_ff;
   hvn_pkg::lane_side_type [L-1:0]   side4_ff;

   logic signed [DW:0]   prod_l, prod_r, prod_u, prod_d;
   logic signed [8:0]    bl, br, bu, bd;
   logic signed [19:0]   gs;
   logic [26:0]          hr;
   logic signed [HW+1:0] hd;
   logic signed [HW-1:0] hsat;

   always_comb begin
      gs = $signed({2'b00, height_gain});
      bl = $signed({1'b0, left_height})  - $signed({1'b0, center_height});
      br = $signed({1'b0, right_height}) - $signed({1'b0, center_height});
      bu = $signed({1'b0, up_height})    - $signed({1'b0, center_height});
      bd = $signed({1'b0, down_height})  - $signed({1'b0, center_height});
      prod_l = (DW+1)'(bl * gs);
      prod_r = (DW+1)'(br * gs);
      prod_u = (DW+1)'(bu * gs);
      prod_d = (DW+1)'(bd * gs);
   end

   always_comb begin
      hr = (27'(cg_ff) + 27'd128) >> 8;
      hd = $signed({2'b00, hr[HW-1:0]}) - (HW+2)'(height_offset);
      if (hd > (HW+2)'(262143)) begin
         hsat = HW'(262143);
      end else if (hd < -(HW+2)'(262144)) begin
         hsat = HW'(-262144);
      end else begin
         hsat = hd[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cg_ff <= 26'(center_height * height_gain);
         dl_ff <= prod_l[DW-1:0];
         dr_ff <= prod_r[DW-1:0];
         du_ff <= prod_u[DW-1:0];
         dd_ff <= prod_d[DW-1:0];
         mask_ff[hvn_pkg::LANE_LD] <= has_left & has_down;
         mask_ff[hvn_pkg::LANE_RD] <= has_right & has_down;
         mask_ff[hvn_pkg::LANE_UR] <= has_up & has_right;
         mask_ff[hvn_pkg::LANE_LU] <= has_left & has_up;

         p_ff[hvn_pkg::LANE_LD] <= -dd_ff;
         q_ff[hvn_pkg::LANE_LD] <= dl_ff;
         p_ff[hvn_pkg::LANE_RD] <= -dd_ff;
         q_ff[hvn_pkg::LANE_RD] <= -dr_ff;
         p_ff[hvn_pkg::LANE_UR] <= du_ff;
         q_ff[hvn_pkg::LANE_UR] <= -dr_ff;
         p_ff[hvn_pkg::LANE_LU] <= du_ff;
         q_ff[hvn_pkg::LANE_LU] <= dl_ff;
         c2_ff.height <= hsat;
         c2_ff.mask   <= mask_ff;

         c3_ff <= c2_ff;
         for (int i = 0; i < L; i++) begin
            sqp_ff[i]       <= hvn_pkg::SQ_W'(p_ff[i] * p_ff[i]);
            sqq_ff[i]       <= hvn_pkg::SQ_W'(q_ff[i] * q_ff[i]);
            ln3_ff[i].neg_p <= p_ff[i][DW-1];
            ln3_ff[i].neg_q <= q_ff[i][DW-1];
            ln3_ff[i].mag_p <= hvn_pkg::MAG_W'(p_ff[i][DW-1] ? -p_ff[i] : p_ff[i]);
            ln3_ff[i].mag_q <= hvn_pkg::MAG_W'(q_ff[i][DW-1] ? -q_ff[i] : q_ff[i]);
         end

         for (int i = 0; i < L; i++) begin
            len_ff[i] <= hvn_pkg::LEN_W'(sqp_ff[i]) + hvn_pkg::LEN_W'(sqq_ff[i])
                         + hvn_pkg::LEN_BIAS;
            side4_ff[i].common <= c3_ff;
            side4_ff[i].lane   <= ln3_ff[i];
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_len   = len_ff;
   assign out_side  = side4_ff;

endmodule

/* test/tb_heightmap_vertex_normal.sv */
// Testbench for heightmap_vertex_normal: directed and random vertices checked against a predictor.
`timescale 1ns / 100ps
module tb_heightmap_vertex_normal;

   localparam int NFB = hvn_pkg::NORMAL_FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [7:0] center, left, right, up, down;
      logic       has_l, has_r, has_u, has_d;
   } vertex_type;

   typedef struct packed {
      logic signed [hvn_pkg::HEIGHT_W-1:0] height;
      logic signed [hvn_pkg::NORM_W-1:0]   nx, ny, nz;
      logic                                no_quad;
   } vertex_out_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready;
   vertex_type req = '0;
   logic [hvn_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hvn_pkg::CSR_DATA_W-1:0] csr_data = '0;
   logic signed [hvn_pkg::HEIGHT_W-1:0] rsp_vertex_height;
   logic signed [hvn_pkg::NORM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_no_quadrant;

   longint unsigned gain;
   longint signed offset;
   vertex_out_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   int stall_mode = 0;

   always #1 clock = ~clock;

   heightmap_vertex_normal uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_center_height(req.center), .req_left_height(req.left),
      .req_right_height(req.right), .req_up_height(req.up),
      .req_down_height(req.down), .req_has_left(req.has_l),
      .req_has_right(req.has_r), .req_has_up(req.has_u), .req_has_down(req.has_d),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vertex_height(rsp_vertex_height), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_no_quadrant(rsp_no_quadrant),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint signed round_div(longint signed v, int sh,
                                               longint unsigned den, longint unsigned cap);
      longint unsigned mag = (v < 0) ? longint'(-v) : longint'(v);
      longint unsigned q;
      if (den == 0) return 0;
      q = ((mag << (sh + 1)) + den) / (den * 2);
      if (q > cap) q = cap;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic void add_face(ref longint signed sum[3], input longint signed p,
                                    input longint signed q);
      longint unsigned pm = (p < 0) ? -p : p;
      longint unsigned qm = (q < 0) ? -q : q;
      longint unsigned n = floor_sqrt(pm * pm + qm * qm + (64'd1 << 32));
      longint unsigned cap = 64'd1 << hvn_pkg::INNER_BITS;
      sum[0] += round_div(p, hvn_pkg::INNER_BITS, n, cap);
      sum[1] += round_div(65536, hvn_pkg::INNER_BITS, n, cap);
      sum[2] += round_div(q, hvn_pkg::INNER_BITS, n, cap);
   endfunction

   function automatic vertex_out_type vertex_normal(vertex_type v);
      vertex_out_type r;
      longint signed c = v.center;
      longint signed g = gain;
      longint signed dl = (longint'(v.left) - c) * g;
      longint signed dr = (longint'(v.right) - c) * g;
      longint signed du = (longint'(v.up) - c) * g;
      longint signed dd = (longint'(v.down) - c) * g;
      longint signed sum[3] = '{0, 0, 0};
      longint signed h;
      longint unsigned t = 0, m, a, cap;
      bit any = 0;
      h = ((c * g + 128) >>> 8) - offset;
      if (h > 262143) h = 262143;
      if (h < -262144) h = -262144;
      r.height = h[hvn_pkg::HEIGHT_W-1:0];
      if (v.has_l && v.has_d) begin add_face(sum, -dd, dl); any = 1; end
      if (v.has_r && v.has_d) begin add_face(sum, -dd, -dr); any = 1; end
      if (v.has_u && v.has_r) begin add_face(sum, du, -dr); any = 1; end
      if (v.has_l && v.has_u) begin add_face(sum, du, dl); any = 1; end
      r.no_quad = !any;
      r.nx = '0; r.ny = '0; r.nz = '0;
      if (any) begin
         cap = 64'd1 << NFB;
         if (cap > 32767) cap = 32767;
         for (int k = 0; k < 3; k++) begin
            a = (sum[k] < 0) ? -sum[k] : sum[k];
            t += a * a;
         end
         m = floor_sqrt(t);
         r.nx = hvn_pkg::NORM_W'(round_div(sum[0], NFB, m, cap));
         r.ny = hvn_pkg::NORM_W'(round_div(sum[1], NFB, m, cap));
         r.nz = hvn_pkg::NORM_W'(round_div(sum[2], NFB, m, cap));
      end
      return r;
   endfunction

   function automatic int idle_len();
      int r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("heightmap_vertex_normal test failed");
         $finish;
      end
   end

   // result stall: random stretches with none or with random gaps
   always @(posedge clock) begin
      if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 2);
      if (stall_mode == 0) rsp_stall <= 0;
      else if (stall_mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= (idle_len() != 0);
   end

   always @(posedge clock) begin
      vertex_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result height=%0d", $time, rsp_vertex_height);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_vertex_height !== e.height) begin
               $display("%0t: vertex_height exp %0d got %0d", $time, e.height,
                        rsp_vertex_height);
               errors++;
            end
            if (rsp_normal_x !== e.nx) begin
               $display("%0t: normal_x exp %0d got %0d", $time, e.nx, rsp_normal_x);
               errors++;
            end
            if (rsp_normal_y !== e.ny) begin
               $display("%0t: normal_y exp %0d got %0d", $time, e.ny, rsp_normal_y);
               errors++;
            end
            if (rsp_normal_z !== e.nz) begin
               $display("%0t: normal_z exp %0d got %0d", $time, e.nz, rsp_normal_z);
               errors++;
            end
            if (rsp_no_quadrant !== e.no_quad) begin
               $display("%0t: no_quadrant exp %0b got %0b", $time, e.no_quad,
                        rsp_no_quadrant);
               errors++;
            end
         end
      end
   end

   task automatic send_request(vertex_type v, int gap);
      req_valid <= 1;
      req <= v;
      do @(posedge clock); while (req_stall);
      expected_q.insert(expected_q.size(), vertex_normal(v));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [hvn_pkg::CSR_IDX_W-1:0] idx,
                            logic [hvn_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == hvn_pkg::CSR_HEIGHT_GAIN) gain = data[hvn_pkg::GAIN_W-1:0];
      else offset = longint'($signed(data[hvn_pkg::HEIGHT_W-1:0]));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(logic [hvn_pkg::CSR_DATA_W-1:0] g,
                             logic [hvn_pkg::CSR_DATA_W-1:0] o);
      drain();
      write_csr(hvn_pkg::CSR_HEIGHT_GAIN, g);
      write_csr(hvn_pkg::CSR_HEIGHT_OFFSET, o);
      csr_valid <= 0;
   endtask

   function automatic vertex_type random_vertex();
      vertex_type v = vertex_type'($bits(vertex_type)'({$urandom, $urandom}));
      if ($urandom_range(0, 3) == 0) v.center = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 1)) {v.has_l, v.has_r, v.has_u, v.has_d} = 4'hF;
      return v;
   endfunction

   task automatic test_directed();
      vertex_type v;
      send_request('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
      send_request('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
      send_request('{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 1);
      send_request('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
      send_request('{8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
      // each flag combination, including ones with no quadrant
      for (int f = 0; f < 16; f++) begin
         v = '{8'd100, 8'd7, 8'd200, 8'd255, 8'd0, f[3], f[2], f[1], f[0]};
         send_request(v, f % 3);
      end
   endtask

   task automatic test_config_extremes();
      logic [hvn_pkg::CSR_DATA_W-1:0] gains[4] = '{19'd0, 19'd262143, 19'd1, 19'd256};
      logic [hvn_pkg::CSR_DATA_W-1:0] offs[4] = '{19'h40000, 19'h3FFFF, 19'h7FFFF, 19'd0};
      for (int i = 0; i < 4; i++) begin
         set_config(gains[i], offs[i]);
         send_request('{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
         send_request('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1}, 0);
         for (int n = 0; n < 30; n++) send_request(random_vertex(), idle_len());
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         set_config(hvn_pkg::CSR_DATA_W'($urandom_range(0, 262143)),
                    hvn_pkg::CSR_DATA_W'($urandom_range(0, 524287)));
         for (int n = 0; n < 220; n++) begin
            if (phase == 2 && n == 100) drain();
            send_request(random_vertex(), (phase == 4) ? 0 : idle_len());
         end
      end
      set_config(19'd256, 19'd0);
      for (int n = 0; n < 100; n++) send_request(random_vertex(), idle_len());
   endtask

   initial begin
      gain = 256;
      offset = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      test_directed();
      test_config_extremes();
      test_random();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("heightmap_vertex_normal test passed");
      else
         $display("heightmap_vertex_normal test failed");
      $finish;
   end
endmodule
